// File: rtl/pst_pkg.sv
package pst_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int INDEX_BITS_DEF = 16;
  localparam int CFG_BITS       = 16;
  localparam int CFG_ADDR_BITS  = 1;
  localparam int RUN_BITS       = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_HALF_WIDTH = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_TEX_LENGTH = 1'd1;

  localparam logic [CFG_BITS-1:0] HALF_WIDTH_RST = 16'd3840;
  localparam logic [CFG_BITS-1:0] TEX_LENGTH_RST = 16'd2000;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQR,
    B_START_SQRT,
    B_ROOT,
    B_START_DIV,
    B_DIV,
    B_LOAD0,
    B_OUT0,
    B_OUT1,
    B_RUN
  } back_state_t;

endpackage

// File: rtl/pst_if.sv
interface pst_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

interface pst_out_if #(
  parameter int COORD_BITS = 24,
  parameter int INDEX_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic [15:0]                  tex_u;
  logic                         tex_v;
  logic [INDEX_BITS-1:0]        vertex_number;
  logic                         stroke_end;

  modport source (output valid, output vertex_x, output vertex_y, output tex_u,
                  output tex_v, output vertex_number, output stroke_end, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input tex_u,
                  input tex_v, input vertex_number, input stroke_end, output ready);
endinterface

// File: rtl/polyline_stroke_tessellator_core.sv
// Polyline stroke tessellator: takes stroke points (signed Q16.8) one request at a
// time and returns a triangle strip of two vertices per point, left (tex_v 0) then
// right (tex_v 1), with miter offsets at inner points and plain perpendicular (butt)
// offsets at the end points; tex_u is travelled length over texture_length in Q0.16,
// clamped. Repeated points are dropped and strokes shorter than two points give
// nothing. A point's pair leaves when the next point arrives; the final point's pair
// follows its predecessor's. The front end classifies points and queues up to four
// vertex-pair jobs, plus one held final-point job. The back end works on one job at a
// time, in this order: a queue pop, the squarings and products, a root start, the
// bit-serial square roots (up to COORD_BITS+8 steps), a divide start, the 17-step
// restoring divides for both offset components and tex_u, a load, the left and right
// output states and a length update. A final point releases two jobs, result stalls
// hold the back end in its output states, and the root and divide loops set the
// throughput. Configuration is written through cfg_we/cfg_addr/cfg_data; the user
// must write it only while the block is idle, as the block itself does not enforce it.
module polyline_stroke_tessellator_core #(
  parameter int COORD_BITS = pst_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = pst_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pst_in_if.sink                            in_ch,
  pst_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pst_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [pst_pkg::CFG_BITS-1:0]      cfg_data
);
  import pst_pkg::*;

  // one queued job: point, offset direction, segment magnitudes and two flags
  localparam int CMD_W = 6 * COORD_BITS + 6;

  logic [CFG_BITS-1:0] half_width_r, texture_length_r;
  logic                q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0]    q_din, q_dout;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r     <= HALF_WIDTH_RST;
      texture_length_r <= TEX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HALF_WIDTH: half_width_r     <= cfg_data;
        CFG_TEX_LENGTH: texture_length_r <= cfg_data;
        default:        half_width_r     <= half_width_r;
      endcase
    end
  end

  // front end: point classification and stroke geometry state
  pst_front #(.COORD_BITS(COORD_BITS), .CMD_W(CMD_W)) u_front (
    .clk, .rst_n, .in_ch, .q_full, .q_push, .q_din
  );

  // job queue between the two halves
  pst_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  // back end: offset math, texture coordinate and vertex output
  pst_back #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS), .CMD_W(CMD_W)) u_back (
    .clk, .rst_n, .half_width(half_width_r), .texture_length(texture_length_r),
    .q_empty, .q_dout, .q_pop, .out_ch
  );
endmodule

// File: rtl/pst_fifo.sv
module pst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pst_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= din;
  end
endmodule

// File: rtl/pst_sqrt.sv
module pst_sqrt #(
  parameter int RAD_W = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               busy,
  output logic [RAD_W/2-1:0] root
);
  localparam int RES_W = RAD_W / 2;
  localparam int CW    = $clog2(RES_W + 1);

  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [RES_W:0]   rem_r, rem_nxt;
  logic [RES_W-1:0] root_r, root_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [RES_W+2:0] rem_t, trial, diff;

  assign busy = (cnt_r != '0);
  assign root = root_r;

  always_comb begin
    rem_t    = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = rem_t - trial;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(RES_W);
    end else if (busy) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      cnt_nxt = cnt_r - 1'b1;
      if (rem_t >= trial) begin
        rem_nxt  = diff[RES_W:0];
        root_nxt = {root_r[RES_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t[RES_W:0];
        root_nxt = {root_r[RES_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end
endmodule

// File: rtl/pst_div.sv
module pst_div #(
  parameter int DEN_W = 16,
  parameter int QUO_W = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic                   busy,
  output logic [QUO_W-1:0]       quo
);
  localparam int NW = DEN_W + QUO_W;
  localparam int CW = $clog2(QUO_W + 1);

  logic [NW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    dsh_r, dsh_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign busy = (cnt_r != '0);
  assign quo  = q_r;

  always_comb begin
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = num;
      dsh_nxt = NW'(den) << (QUO_W - 1);
      q_nxt   = '0;
      cnt_nxt = CW'(QUO_W);
    end else if (busy) begin
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[QUO_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end
endmodule

// File: rtl/pst_front.sv
module pst_front #(
  parameter int COORD_BITS = pst_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = 6 * COORD_BITS + 6
) (
  input  logic             clk,
  input  logic             rst_n,
  pst_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             q_push,
  output logic [CMD_W-1:0] q_din
);
  import pst_pkg::*;

  localparam int C = COORD_BITS;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_MANY = 2'd2;

  typedef struct packed {
    logic signed [C-1:0] px;
    logic signed [C-1:0] py;
    logic signed [C+1:0] wx;
    logic signed [C+1:0] wy;
    logic [C-1:0]        dmx;
    logic [C-1:0]        dmy;
    logic                add_seg;
    logic                last;
  } cmd_t;

  logic signed [C-1:0] prior_x_r, prior_x_nxt;
  logic signed [C-1:0] prior_y_r, prior_y_nxt;
  logic signed [C:0]   seg_x_r, seg_x_nxt;
  logic signed [C:0]   seg_y_r, seg_y_nxt;
  logic [1:0]          seen_r, seen_nxt;
  logic                pend_r, pend_nxt;
  cmd_t                pend_cmd_r, pend_cmd_nxt;
  cmd_t                cmd;
  logic                accept, repeat_pt;
  logic signed [C:0]   dx, dy;
  logic signed [C+1:0] sum_x, sum_y;
  logic [C:0]          adx, ady;

  assign in_ch.ready = !pend_r && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_din       = cmd;

  always_comb begin
    dx        = {in_ch.point_x[C-1], in_ch.point_x} - {prior_x_r[C-1], prior_x_r};
    dy        = {in_ch.point_y[C-1], in_ch.point_y} - {prior_y_r[C-1], prior_y_r};
    adx       = dx[C] ? -dx : dx;
    ady       = dy[C] ? -dy : dy;
    sum_x     = {seg_y_r[C], seg_y_r} + {dy[C], dy};
    sum_y     = -{seg_x_r[C], seg_x_r} - {dx[C], dx};
    repeat_pt = (seen_r != SEEN_NONE) && (in_ch.point_x == prior_x_r)
                && (in_ch.point_y == prior_y_r);

    prior_x_nxt  = prior_x_r;
    prior_y_nxt  = prior_y_r;
    seg_x_nxt    = seg_x_r;
    seg_y_nxt    = seg_y_r;
    seen_nxt     = seen_r;
    pend_nxt     = pend_r;
    pend_cmd_nxt = pend_cmd_r;
    q_push       = 1'b0;

    // default request: end point at the prior point along the prior segment
    cmd.px      = prior_x_r;
    cmd.py      = prior_y_r;
    cmd.wx      = {seg_y_r[C], seg_y_r};
    cmd.wy      = -{seg_x_r[C], seg_x_r};
    cmd.dmx     = adx[C-1:0];
    cmd.dmy     = ady[C-1:0];
    cmd.add_seg = 1'b0;
    cmd.last    = 1'b1;

    if (pend_r) begin
      cmd = pend_cmd_r;
      if (!q_full) begin
        q_push   = 1'b1;
        pend_nxt = 1'b0;
      end
    end else if (accept) begin
      if (repeat_pt) begin
        if (in_ch.last_point) begin
          q_push   = (seen_r == SEEN_MANY);
          seen_nxt = SEEN_NONE;
        end
      end else if (seen_r == SEEN_NONE) begin
        prior_x_nxt = in_ch.point_x;
        prior_y_nxt = in_ch.point_y;
        seen_nxt    = in_ch.last_point ? SEEN_NONE : SEEN_ONE;
      end else begin
        if (seen_r == SEEN_ONE) begin
          cmd.wx = {dy[C], dy};
          cmd.wy = -{dx[C], dx};
        end else if (sum_x != '0 || sum_y != '0) begin
          cmd.wx = sum_x;
          cmd.wy = sum_y;
        end
        cmd.add_seg = 1'b1;
        cmd.last    = 1'b0;
        q_push      = 1'b1;
        prior_x_nxt = in_ch.point_x;
        prior_y_nxt = in_ch.point_y;
        seg_x_nxt   = dx;
        seg_y_nxt   = dy;
        seen_nxt    = in_ch.last_point ? SEEN_NONE : SEEN_MANY;
        // the final point's pair follows as a second request
        pend_nxt             = in_ch.last_point;
        pend_cmd_nxt.px      = in_ch.point_x;
        pend_cmd_nxt.py      = in_ch.point_y;
        pend_cmd_nxt.wx      = {dy[C], dy};
        pend_cmd_nxt.wy      = -{dx[C], dx};
        pend_cmd_nxt.dmx     = adx[C-1:0];
        pend_cmd_nxt.dmy     = ady[C-1:0];
        pend_cmd_nxt.add_seg = 1'b0;
        pend_cmd_nxt.last    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_x_r <= '0;
      prior_y_r <= '0;
      seg_x_r   <= '0;
      seg_y_r   <= '0;
      seen_r    <= SEEN_NONE;
      pend_r    <= 1'b0;
    end else begin
      prior_x_r <= prior_x_nxt;
      prior_y_r <= prior_y_nxt;
      seg_x_r   <= seg_x_nxt;
      seg_y_r   <= seg_y_nxt;
      seen_r    <= seen_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_cmd_r <= pend_cmd_nxt;
  end
endmodule

// File: rtl/pst_back.sv
module pst_back #(
  parameter int COORD_BITS = pst_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = pst_pkg::INDEX_BITS_DEF,
  parameter int CMD_W      = 6 * COORD_BITS + 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pst_pkg::CFG_BITS-1:0]  half_width,
  input  logic [pst_pkg::CFG_BITS-1:0]  texture_length,
  input  logic                          q_empty,
  input  logic [CMD_W-1:0]              q_dout,
  output logic                          q_pop,
  pst_out_if.source                     out_ch
);
  import pst_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int LRAD_W = 2 * C + 16;
  localparam int LEN_W  = LRAD_W / 2;
  localparam int SRAD_W = 2 * C + 2;
  localparam int SEG_W  = SRAD_W / 2;
  localparam int QW     = CFG_BITS + 1;
  localparam int ODEN_W = LEN_W + 1;
  localparam int PROD_W = CFG_BITS + C + 1;

  typedef struct packed {
    logic signed [C-1:0] px;
    logic signed [C-1:0] py;
    logic signed [C+1:0] wx;
    logic signed [C+1:0] wy;
    logic [C-1:0]        dmx;
    logic [C-1:0]        dmy;
    logic                add_seg;
    logic                last;
  } cmd_t;

  back_state_t           state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [C:0]            mx, my;
  logic [2*C+2:0]        wsq_r;
  logic [2*C:0]          dsq_r;
  logic [PROD_W-1:0]     prodx_r, prody_r;
  logic [RUN_BITS-1:0]   run_r, run_nxt;
  logic [INDEX_BITS-1:0] vcnt_r, vcnt_nxt, vcnt_inc;
  logic                  sq_start, dv_start, load_left, load_right, out_fire;
  logic                  len_busy, seg_busy, dx_busy, dy_busy, du_busy;
  logic [LEN_W-1:0]      len;
  logic [SEG_W-1:0]      seg;
  logic [QW-1:0]         qx, qy, qu;
  logic [CFG_BITS-1:0]   tl;
  logic                  u_clamp;
  logic [CFG_BITS-1:0]   u_val;
  logic signed [C+1:0]   ox, oy, vx, vy;
  logic [RUN_BITS:0]     run_sum;
  logic                  side;

  logic signed [C-1:0]   vx_r, vy_r;
  logic [CFG_BITS-1:0]   u_r;
  logic                  v_r, end_r;
  logic [INDEX_BITS-1:0] vnum_r;

  assign mx = cmd_r.wx[C+1] ? -cmd_r.wx[C:0] : cmd_r.wx[C:0];
  assign my = cmd_r.wy[C+1] ? -cmd_r.wy[C:0] : cmd_r.wy[C:0];

  pst_sqrt #(.RAD_W(LRAD_W)) u_len_sqrt (
    .clk, .rst_n, .start(sq_start),
    .radicand({1'b0, wsq_r, 12'd0}), .busy(len_busy), .root(len)
  );

  pst_sqrt #(.RAD_W(SRAD_W)) u_seg_sqrt (
    .clk, .rst_n, .start(sq_start),
    .radicand({1'b0, dsq_r}), .busy(seg_busy), .root(seg)
  );

  pst_div #(.DEN_W(ODEN_W), .QUO_W(QW)) u_div_x (
    .clk, .rst_n, .start(dv_start),
    .num((ODEN_W + QW)'({prodx_r, 7'd0}) + (ODEN_W + QW)'(len)),
    .den({len, 1'b0}), .busy(dx_busy), .quo(qx)
  );

  pst_div #(.DEN_W(ODEN_W), .QUO_W(QW)) u_div_y (
    .clk, .rst_n, .start(dv_start),
    .num((ODEN_W + QW)'({prody_r, 7'd0}) + (ODEN_W + QW)'(len)),
    .den({len, 1'b0}), .busy(dy_busy), .quo(qy)
  );

  // texture coordinate divide, skipped in effect when it would clamp
  assign tl      = (texture_length == '0) ? CFG_BITS'(1) : texture_length;
  assign u_clamp = (run_r >= RUN_BITS'({tl, 8'd0}));

  pst_div #(.DEN_W(CFG_BITS), .QUO_W(QW)) u_div_u (
    .clk, .rst_n, .start(dv_start),
    .num((CFG_BITS + QW)'({run_r, 8'd0})), .den(tl), .busy(du_busy), .quo(qu)
  );

  assign u_val = u_clamp ? '1 : qu[CFG_BITS-1:0];

  always_comb begin
    ox   = cmd_r.wx[C+1] ? -(C+2)'(qx) : (C+2)'(qx);
    oy   = cmd_r.wy[C+1] ? -(C+2)'(qy) : (C+2)'(qy);
    side = load_right;
    vx   = side ? {{2{cmd_r.px[C-1]}}, cmd_r.px} - ox : {{2{cmd_r.px[C-1]}}, cmd_r.px} + ox;
    vy   = side ? {{2{cmd_r.py[C-1]}}, cmd_r.py} - oy : {{2{cmd_r.py[C-1]}}, cmd_r.py} + oy;
  end

  assign vcnt_inc = (vcnt_r == '1) ? vcnt_r : vcnt_r + 1'b1;
  assign run_sum  = {1'b0, run_r} + (RUN_BITS + 1)'(seg);
  assign out_fire = out_ch.valid && out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:       if (!q_empty) state_nxt = B_SQR;
      B_SQR:        state_nxt = B_START_SQRT;
      B_START_SQRT: state_nxt = B_ROOT;
      B_ROOT:       if (!len_busy && !seg_busy) state_nxt = B_START_DIV;
      B_START_DIV:  state_nxt = B_DIV;
      B_DIV:        if (!dx_busy && !dy_busy && !du_busy) state_nxt = B_LOAD0;
      B_LOAD0:      state_nxt = B_OUT0;
      B_OUT0:       if (out_fire) state_nxt = B_OUT1;
      B_OUT1:       if (out_fire) state_nxt = B_RUN;
      B_RUN:        state_nxt = B_IDLE;
      default:      state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop        = 1'b0;
    sq_start     = 1'b0;
    dv_start     = 1'b0;
    load_left    = 1'b0;
    load_right   = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      B_IDLE:       q_pop = !q_empty;
      B_START_SQRT: sq_start = 1'b1;
      B_START_DIV:  dv_start = 1'b1;
      B_LOAD0:      load_left = 1'b1;
      B_OUT0: begin
        out_ch.valid = 1'b1;
        load_right   = out_fire;
      end
      B_OUT1:       out_ch.valid = 1'b1;
      default:      q_pop = 1'b0;
    endcase
  end

  always_comb begin
    run_nxt  = run_r;
    vcnt_nxt = vcnt_r;
    if (load_left || load_right) vcnt_nxt = vcnt_inc;
    if (state_r == B_RUN) begin
      if (cmd_r.last) begin
        run_nxt  = '0;
        vcnt_nxt = '0;
      end else if (cmd_r.add_seg) begin
        run_nxt = run_sum[RUN_BITS] ? '1 : run_sum[RUN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      run_r   <= '0;
      vcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= cmd_t'(q_dout);
    if (state_r == B_SQR) begin
      wsq_r   <= (2*C+3)'(mx * mx) + (2*C+3)'(my * my);
      dsq_r   <= (2*C+1)'(cmd_r.dmx * cmd_r.dmx) + (2*C+1)'(cmd_r.dmy * cmd_r.dmy);
      prodx_r <= PROD_W'(half_width * mx);
      prody_r <= PROD_W'(half_width * my);
    end
    if (load_left || load_right) begin
      if (vx[C+1:C-1] != {3{vx[C+1]}}) vx_r <= vx[C+1] ? {1'b1, {(C-1){1'b0}}}
                                                        : {1'b0, {(C-1){1'b1}}};
      else vx_r <= vx[C-1:0];
      if (vy[C+1:C-1] != {3{vy[C+1]}}) vy_r <= vy[C+1] ? {1'b1, {(C-1){1'b0}}}
                                                        : {1'b0, {(C-1){1'b1}}};
      else vy_r <= vy[C-1:0];
      u_r    <= u_val;
      v_r    <= side;
      end_r  <= side && cmd_r.last;
      vnum_r <= vcnt_r;
    end
  end

  assign out_ch.vertex_x      = vx_r;
  assign out_ch.vertex_y      = vy_r;
  assign out_ch.tex_u         = u_r;
  assign out_ch.tex_v         = v_r;
  assign out_ch.vertex_number = vnum_r;
  assign out_ch.stroke_end    = end_r;
endmodule

// File: rtl/pst_checker.sv
module pst_checker #(
  parameter int COORD_BITS = pst_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = pst_pkg::INDEX_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] vertex_x,
  input logic signed [COORD_BITS-1:0] vertex_y,
  input logic [15:0]                  tex_u,
  input logic                         tex_v,
  input logic [INDEX_BITS-1:0]        vertex_number,
  input logic                         stroke_end
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vertex_x) && $stable(vertex_y) && $stable(tex_u)
      && $stable(tex_v) && $stable(vertex_number) && $stable(stroke_end))
    else $error("result payload changed while stalled");

  a_end_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stroke_end |-> tex_v)
    else $error("stroke end on a left vertex");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !tex_v |=> out_valid && tex_v)
    else $error("left vertex not followed by its right vertex");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind polyline_stroke_tessellator_core pst_checker #(
  .COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS)
) u_pst_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .vertex_x(out_ch.vertex_x), .vertex_y(out_ch.vertex_y), .tex_u(out_ch.tex_u),
  .tex_v(out_ch.tex_v), .vertex_number(out_ch.vertex_number),
  .stroke_end(out_ch.stroke_end)
);

// File: bench/polyline_stroke_tessellator_core_test.sv
`timescale 1ns / 1ps

module polyline_stroke_tessellator_core_test;
  import pst_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int IW = INDEX_BITS_DEF;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 200;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } point_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [15:0]          u;
    logic                 v;
    logic [IW-1:0]        num;
    logic                 fin;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_BITS-1:0] cfg_data;

  pst_in_if  #(.COORD_BITS(CW)) in_ch ();
  pst_out_if #(.COORD_BITS(CW), .INDEX_BITS(IW)) out_ch ();

  polyline_stroke_tessellator_core #(.COORD_BITS(CW), .INDEX_BITS(IW)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // pending stroke points and expected strip vertices
  point_t  point_q[$];
  vertex_t strip_q[$];

  // predictor copy of the registers and the stroke state
  longint unsigned half_w, tex_len;
  longint prev_x, prev_y, prev_dx, prev_dy;
  int     pts_seen;
  longint unsigned run_len;
  int     vert_cnt;

  int  errors, cycles, points_sent, verts_checked, strokes_sent;
  bit  in_taken;
  bit  calm;
  bit  hold_req;
  int  in_gap, out_gap, hold_cnt;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint abs64(longint a);
    return a < 0 ? -a : a;
  endfunction

  // half_width * c / |w| in q.8, rounded half away from zero
  function automatic longint scale_offset(longint c, longint unsigned len);
    longint unsigned num, q;
    num = half_w * longint'(abs64(c)) * 64;
    q = (2 * num + len) / (2 * len);
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic miter_offset(input longint wx, input longint wy,
                              output longint ox, output longint oy);
    longint unsigned ax, ay, len;
    ax = abs64(wx);
    ay = abs64(wy);
    len = int_sqrt((ax * ax + ay * ay) << 12);
    if (len == 0) len = 1;
    ox = scale_offset(wx, len);
    oy = scale_offset(wy, len);
  endtask

  function automatic logic signed [CW-1:0] clip_coord(longint a);
    return a > CMAX ? CW'(CMAX) : (a < CMIN ? CW'(CMIN) : CW'(a));
  endfunction

  task automatic push_pair(longint px, longint py, longint ox, longint oy, bit fin);
    vertex_t vt;
    longint unsigned t, u;
    t = tex_len != 0 ? tex_len : 1;
    u = (run_len * 256) / t;
    if (u > 65535) u = 65535;
    for (int s = 0; s < 2; s++) begin
      vt.x   = clip_coord(s ? px - ox : px + ox);
      vt.y   = clip_coord(s ? py - oy : py + oy);
      vt.u   = u[15:0];
      vt.v   = s[0];
      vt.num = vert_cnt[IW-1:0];
      vt.fin = fin && s == 1;
      strip_q.push_back(vt);
      if (vert_cnt < (1 << IW) - 1) vert_cnt++;
    end
  endtask

  task automatic close_stroke();
    pts_seen = 0;
    run_len  = 0;
    vert_cnt = 0;
  endtask

  // works out the vertices that one accepted point releases
  task automatic tessellate_point(point_t p);
    longint px, py, dx, dy, ox, oy, wx, wy;
    longint unsigned seg;
    px = longint'(p.x);
    py = longint'(p.y);
    if (pts_seen != 0 && px == prev_x && py == prev_y) begin
      // repeated point, only meaningful when it closes the stroke
      if (p.last) begin
        if (pts_seen >= 2) begin
          miter_offset(prev_dy, -prev_dx, ox, oy);
          push_pair(prev_x, prev_y, ox, oy, 1'b1);
        end
        close_stroke();
      end
      return;
    end
    if (pts_seen == 0) begin
      prev_x = px;
      prev_y = py;
      pts_seen = 1;
      if (p.last) close_stroke();
      return;
    end
    dx = px - prev_x;
    dy = py - prev_y;
    if (pts_seen == 1) begin
      miter_offset(dy, -dx, ox, oy);
    end else begin
      wx = prev_dy + dy;
      wy = -prev_dx - dx;
      // a full reversal falls back to the incoming segment's normal
      if (wx == 0 && wy == 0) miter_offset(prev_dy, -prev_dx, ox, oy);
      else miter_offset(wx, wy, ox, oy);
    end
    push_pair(prev_x, prev_y, ox, oy, 1'b0);
    seg = int_sqrt(abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy));
    run_len += seg;
    if (run_len > 64'hFFFF_FFFF) run_len = 64'hFFFF_FFFF;
    prev_x = px;
    prev_y = py;
    prev_dx = dx;
    prev_dy = dy;
    pts_seen = 2;
    if (p.last) begin
      miter_offset(dy, -dx, ox, oy);
      push_pair(px, py, ox, oy, 1'b1);
      close_stroke();
    end
  endtask

  // cycle count, timeout, prediction and result checking, all at the rising edge
  always @(posedge clk) begin
    vertex_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d vertices still expected",
               cycles, strip_q.size());
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (strip_q.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d", out_ch.vertex_x, out_ch.vertex_y);
        errors++;
      end else begin
        want = strip_q.pop_front();
        verts_checked++;
        if (out_ch.vertex_x !== want.x) begin
          $error("vertex_x expected %0d actual %0d", want.x, out_ch.vertex_x);
          errors++;
        end
        if (out_ch.vertex_y !== want.y) begin
          $error("vertex_y expected %0d actual %0d", want.y, out_ch.vertex_y);
          errors++;
        end
        if (out_ch.tex_u !== want.u) begin
          $error("tex_u expected %0d actual %0d", want.u, out_ch.tex_u);
          errors++;
        end
        if (out_ch.tex_v !== want.v) begin
          $error("tex_v expected %0d actual %0d", want.v, out_ch.tex_v);
          errors++;
        end
        if (out_ch.vertex_number !== want.num) begin
          $error("vertex_number expected %0d actual %0d", want.num, out_ch.vertex_number);
          errors++;
        end
        if (out_ch.stroke_end !== want.fin) begin
          $error("stroke_end expected %0d actual %0d", want.fin, out_ch.stroke_end);
          errors++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      point_t p;
      p.x = in_ch.point_x;
      p.y = in_ch.point_y;
      p.last = in_ch.last_point;
      tessellate_point(p);
      points_sent++;
      in_taken = 1'b1;
    end
  end

  // point driver: next request goes out at a falling edge once the last one was taken, after any random gap
  always @(negedge clk) begin
    point_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 11) - 1;
        in_ch.valid <= 1'b0;
      end else if (point_q.size() != 0) begin
        p = point_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.point_x    <= p.x;
        in_ch.point_y    <= p.y;
        in_ch.last_point <= p.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // vertex sink: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 11) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic add_point(longint x, longint y, bit last);
    point_t p;
    p.x = CW'(x);
    p.y = CW'(y);
    p.last = last;
    point_q.push_back(p);
  endtask

  // sender waits until the block has drained, then lets any pending job settle
  task automatic drain();
    while (point_q.size() != 0 || in_ch.valid || strip_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    if (idx == CFG_HALF_WIDTH) half_w = 64'(val);
    else tex_len = 64'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_stroke_cfg(logic [15:0] hw, logic [15:0] tl);
    write_reg(CFG_HALF_WIDTH, hw);
    write_reg(CFG_TEX_LENGTH, tl);
  endtask

  // random stroke: mostly short hops, sometimes full-range jumps and repeats
  task automatic random_stroke(int npts);
    longint x, y;
    x = $signed($urandom_range(0, 32'hFF_FFFF) << 8) >>> 8;
    y = $signed($urandom_range(0, 32'hFF_FFFF) << 8) >>> 8;
    for (int i = 0; i < npts; i++) begin
      case ($urandom_range(0, 9))
        0: ;
        1, 2: begin
          x = $signed($urandom_range(0, 32'hFF_FFFF) << 8) >>> 8;
          y = $signed($urandom_range(0, 32'hFF_FFFF) << 8) >>> 8;
        end
        default: begin
          x += $signed($urandom_range(0, 8192)) - 4096;
          y += $signed($urandom_range(0, 8192)) - 4096;
          x = longint'(clip_coord(x));
          y = longint'(clip_coord(y));
        end
      endcase
      add_point(x, y, i == npts - 1);
    end
    strokes_sent++;
  endtask

  task automatic random_phase(int npoints);
    int n, k;
    n = 0;
    while (n < npoints) begin
      k = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      random_stroke(k);
      n += k;
    end
  endtask

  initial begin
    errors = 0; cycles = 0; points_sent = 0; verts_checked = 0; strokes_sent = 0;
    in_taken = 0; calm = 0; hold_req = 0; in_gap = 0; out_gap = 0; hold_cnt = 0;
    half_w = 64'(HALF_WIDTH_RST);
    tex_len = 64'(TEX_LENGTH_RST);
    prev_x = 0; prev_y = 0; prev_dx = 0; prev_dy = 0;
    close_stroke();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_HALF_WIDTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed strokes with the reset registers
    add_point(0, 0, 0); add_point(2560, 0, 0); add_point(2560, 2560, 1);
    // full reversal at the inner point
    add_point(0, 0, 0); add_point(2560, 0, 0); add_point(0, 0, 1);
    // repeated inner point, then a repeated final point
    add_point(5, 5, 0); add_point(5, 5, 0); add_point(1000, 7, 0); add_point(1000, 7, 1);
    // single point and repeated single point strokes give nothing
    add_point(42, -42, 1);
    add_point(1, 1, 0); add_point(1, 1, 1);
    // coordinate extremes, offsets saturate
    add_point(CMIN, CMIN, 0); add_point(CMAX, CMAX, 0); add_point(CMAX, CMIN, 1);
    strokes_sent += 6;
    drain();

    // widest stroke with u clamped from the second pair on
    set_stroke_cfg(16'hFFFF, 16'd1);
    add_point(CMIN, 0, 0); add_point(0, 100, 0); add_point(300, -300, 0);
    add_point(CMAX, CMAX, 1);
    // zero width with a zero texture length
    drain();
    set_stroke_cfg(16'd0, 16'd0);
    add_point(10, 10, 0); add_point(-700, 20, 0); add_point(-700, 20, 0); add_point(9, 9, 1);
    drain();
    set_stroke_cfg(16'd3840, 16'hFFFF);
    strokes_sent += 2;

    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) set_stroke_cfg(16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)));
      random_phase(ph == 0 ? 110 : 85);
      // long sink hold-off while points keep coming, to back the block up
      if (ph == 1) hold_req = 1'b1;
      if (ph == 4) calm = 1'b1;
      drain();
    end

    $display("sent %0d points in %0d strokes, checked %0d strip vertices",
             points_sent, strokes_sent, verts_checked);
    $display("covered reversal, repeats, short strokes, extreme widths and coordinates");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: polyline_stroke_tessellator_core.f
rtl/pst_pkg.sv
rtl/pst_if.sv
rtl/pst_fifo.sv
rtl/pst_sqrt.sv
rtl/pst_div.sv
rtl/pst_front.sv
rtl/pst_back.sv
rtl/polyline_stroke_tessellator_core.sv
rtl/pst_checker.sv
bench/polyline_stroke_tessellator_core_test.sv
